FILE: hdl/ppwu_pkg.sv
// Shared types, constants and fixed-point helpers for the polynomial plasticity weight update.
package ppwu_pkg;

  localparam int WeightWidth   = 15;
  localparam int TraceWidth    = 15;
  localparam int VoltWidth     = 16;
  localparam int AccWidth      = 32;
  localparam int ProdWidth     = 2 * AccWidth;
  localparam int NumCoeffs     = 21;
  localparam int RuleCoeffs    = 11;
  localparam int PostBase      = 10;
  localparam int NumSlots      = 7;
  localparam int PipeDepth     = 17;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 64;
  localparam int NumCoeffWords = 5;
  localparam int CoeffStride   = 16;
  localparam int CoeffsPerWord = 4;
  localparam int DefCoeffWidth = 16;
  localparam int DefFracBits   = 12;
  localparam int RescaleTrace  = 2;
  localparam int RescaleV      = 15;
  localparam int RescaleC      = 15;

  localparam logic [WeightWidth-1:0] MaxWeightReset = WeightWidth'(4096);

  typedef logic signed [AccWidth-1:0]  acc_t;
  typedef logic signed [ProdWidth-1:0] prod_t;
  typedef acc_t [NumCoeffs-1:0]        coeff_vec_t;
  typedef acc_t [RuleCoeffs-1:0]       rule_coeff_t;
  typedef prod_t [NumSlots-1:0]        prod_vec_t;

  localparam acc_t AccMax = acc_t'({1'b0, {(AccWidth-1){1'b1}}});
  localparam acc_t AccMin = acc_t'({1'b1, {(AccWidth-1){1'b0}}});

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_COEFF_WORD_0,
    REG_COEFF_WORD_1,
    REG_COEFF_WORD_2,
    REG_COEFF_WORD_3,
    REG_COEFF_WORD_4,
    REG_COEFF_WORD_5,
    REG_MAX_WEIGHT,
    REG_LEARNING_ENABLE
  } cfg_reg_t;

  typedef struct packed {
    logic                          opcode;
    logic [WeightWidth-1:0]        weight;
    logic [TraceWidth-1:0]         pre_trace;
    logic [TraceWidth-1:0]         post_trace;
    logic signed [VoltWidth-1:0]   voltage;
    logic [TraceWidth-1:0]         exc_conductance;
    logic [TraceWidth-1:0]         inh_conductance;
  } in_item_t;

  typedef struct packed {
    logic [WeightWidth-1:0] new_weight;
    logic                   clipped;
  } out_item_t;

  typedef struct packed {
    coeff_vec_t             coeffs;
    logic [WeightWidth-1:0] max_weight;
    logic                   learn_enable;
  } cfg_state_t;

  // Signed add saturated to the accumulator range.
  function automatic acc_t add_sat(input acc_t a, input acc_t b);
    logic [AccWidth:0] s;
    s = {a[AccWidth-1], a} + {b[AccWidth-1], b};
    if (s[AccWidth] != s[AccWidth-1]) begin
      add_sat = s[AccWidth] ? AccMin : AccMax;
    end else begin
      add_sat = acc_t'(s[AccWidth-1:0]);
    end
  endfunction

  // Exact signed product of two accumulator values.
  function automatic prod_t mul_full(input acc_t a, input acc_t b);
    mul_full = a * b;
  endfunction

endpackage

FILE: hdl/ppwu_cfg_regs.sv
// Configuration register file and coefficient extraction for the weight update unit.
module ppwu_cfg_regs
  import ppwu_pkg::*;
#(
  parameter int COEFF_WIDTH = DefCoeffWidth
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output cfg_state_t               cfg_st
);

  localparam int ExtWidth = CfgDataWidth + AccWidth;

  logic [CfgDataWidth-1:0] coeff_word_r [NumCoeffWords];
  logic [CoeffStride-1:0]  coeff5_r;
  logic [WeightWidth-1:0]  max_weight_r;
  logic                    learn_r;
  acc_t                    coeff_arr [NumCoeffs];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumCoeffWords; i++) begin
        coeff_word_r[i] <= '0;
      end
      coeff5_r     <= '0;
      max_weight_r <= MaxWeightReset;
      learn_r      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEFF_WORD_0:    coeff_word_r[0] <= cfg_data;
        REG_COEFF_WORD_1:    coeff_word_r[1] <= cfg_data;
        REG_COEFF_WORD_2:    coeff_word_r[2] <= cfg_data;
        REG_COEFF_WORD_3:    coeff_word_r[3] <= cfg_data;
        REG_COEFF_WORD_4:    coeff_word_r[4] <= cfg_data;
        REG_COEFF_WORD_5:    coeff5_r <= cfg_data[CoeffStride-1:0];
        REG_MAX_WEIGHT:      max_weight_r <= cfg_data[WeightWidth-1:0];
        REG_LEARNING_ENABLE: learn_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Each coefficient sits at a fixed offset of its word; bits above the word read as zero.
  for (genvar n = 0; n < NumCoeffs; n++) begin : g_coeff
    localparam int WordSel = n / CoeffsPerWord;
    localparam int Offset  = (n % CoeffsPerWord) * CoeffStride;
    logic [ExtWidth-1:0] ext;
    if (WordSel < NumCoeffWords) begin : g_wide
      assign ext = {{AccWidth{1'b0}}, coeff_word_r[WordSel]};
    end else begin : g_narrow
      assign ext = {{(ExtWidth-CoeffStride){1'b0}}, coeff5_r};
    end
    assign coeff_arr[n] = acc_t'($signed(ext[Offset +: COEFF_WIDTH]));
  end

  always_comb begin
    for (int n = 0; n < NumCoeffs; n++) begin
      cfg_st.coeffs[n] = coeff_arr[n];
    end
    cfg_st.max_weight   = max_weight_r;
    cfg_st.learn_enable = learn_r;
  end

endmodule

FILE: hdl/polynomial_plasticity_weight_update_unit.sv
// Top level of the polynomial plasticity weight update unit: pipelined factor chain and clip.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_data   (in_item_t)
// out      output     out_valid / out_stall out_data  (out_item_t)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low, and each item passes the stages below in order.
// The 18 register stages are eight dependent rounded multiplies, each a multiply stage and a
// round-and-saturate stage, plus the input stage, which loads at the accepting edge, and the
// clip stage that drives out_data.
// Reset is synchronous and active low; it clears the valid bits and loads register defaults.
// A stall at the output only holds stages that are full, so empty stages keep taking items.
module polynomial_plasticity_weight_update_unit
  import ppwu_pkg::*;
#(
  parameter int COEFF_WIDTH = DefCoeffWidth,
  parameter int FRAC_BITS   = DefFracBits
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  localparam acc_t  OneQ    = acc_t'(1) <<< FRAC_BITS;
  localparam prod_t HalfQ   = prod_t'(1) <<< (FRAC_BITS - 1);
  localparam prod_t AccMaxP = prod_t'(AccMax);
  localparam prod_t AccMinP = prod_t'(AccMin);

  localparam int StgIn = 0;
  localparam int StgM1 = 1;
  localparam int StgR1 = 2;
  localparam int StgM2 = 3;
  localparam int StgR2 = 4;
  localparam int StgM3 = 5;
  localparam int StgR3 = 6;
  localparam int StgM4 = 7;
  localparam int StgR4 = 8;
  localparam int StgM5 = 9;
  localparam int StgR5 = 10;
  localparam int StgM6 = 11;
  localparam int StgR6 = 12;
  localparam int StgM7 = 13;
  localparam int StgR7 = 14;
  localparam int StgM8 = 15;
  localparam int StgR8 = 16;

  typedef struct packed {
    logic                   op;
    logic [WeightWidth-1:0] w;
    acc_t                   wq;
    acc_t                   a;
    acc_t                   b;
    acc_t                   v;
    acc_t                   e;
    acc_t                   ih;
    rule_coeff_t            k;
    prod_vec_t              p;
    acc_t                   t_c2;
    acc_t                   t_c5;
    acc_t                   one_k1;
    acc_t                   bb;
    acc_t                   f1;
    acc_t                   f2;
    acc_t                   f3;
    acc_t                   f4;
    acc_t                   f5pre;
    acc_t                   t_f0;
    acc_t                   t_c19;
    acc_t                   last;
    acc_t                   dw;
  } pipe_t;

  cfg_state_t             cfg_st;
  pipe_t                  stg_r   [PipeDepth];
  pipe_t                  stg_nxt [PipeDepth];
  logic [PipeDepth-1:0]   pv_r;
  logic [PipeDepth-1:0]   pv_nxt;
  logic [PipeDepth-1:0]   en;
  logic                   en_out;
  logic                   out_valid_r;
  out_item_t              out_r;
  out_item_t              out_nxt;
  logic signed [AccWidth:0] sum;
  logic signed [AccWidth:0] limit;

  // Round to nearest with ties upward, drop the fraction bits, saturate to the accumulator.
  function automatic acc_t rnd_sat(input prod_t prod);
    prod_t q;
    q = (prod + HalfQ) >>> FRAC_BITS;
    if (q > AccMaxP) begin
      rnd_sat = AccMax;
    end else if (q < AccMinP) begin
      rnd_sat = AccMin;
    end else begin
      rnd_sat = acc_t'(q[AccWidth-1:0]);
    end
  endfunction

  ppwu_cfg_regs #(
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_st    (cfg_st)
  );

  // A stage may load when it is empty or when the stage after it moves on.
  assign en_out = !out_valid_r || !out_stall;
  assign en[PipeDepth-1] = !pv_r[PipeDepth-1] || en_out;
  for (genvar k = 0; k < PipeDepth - 1; k++) begin : g_en
    assign en[k] = !pv_r[k] || en[k+1];
  end

  assign in_stall = !en[StgIn];

  always_comb begin
    pv_nxt[StgIn] = in_valid;
    for (int k = 1; k < PipeDepth; k++) begin
      pv_nxt[k] = pv_r[k-1];
    end
  end

  always_comb begin
    for (int k = 1; k < PipeDepth; k++) begin
      stg_nxt[k] = stg_r[k-1];
    end

    // Input stage: rescale the traces, voltage and conductances; pick the coefficient set of the rule.
    stg_nxt[StgIn]    = '0;
    stg_nxt[StgIn].op = in_data.opcode;
    stg_nxt[StgIn].w  = in_data.weight;
    stg_nxt[StgIn].wq = acc_t'(in_data.weight);
    stg_nxt[StgIn].a  = acc_t'(in_data.pre_trace) * acc_t'(RescaleTrace);
    stg_nxt[StgIn].b  = acc_t'(in_data.post_trace) * acc_t'(RescaleTrace);
    stg_nxt[StgIn].v  = acc_t'(in_data.voltage) * acc_t'(RescaleV);
    stg_nxt[StgIn].e  = acc_t'(in_data.exc_conductance) * acc_t'(RescaleC);
    stg_nxt[StgIn].ih = acc_t'(in_data.inh_conductance) * acc_t'(RescaleC);
    for (int i = 0; i < RuleCoeffs; i++) begin
      if (in_data.opcode) begin
        stg_nxt[StgIn].k[i] = cfg_st.coeffs[PostBase + i];
      end else if (i < PostBase) begin
        stg_nxt[StgIn].k[i] = cfg_st.coeffs[i];
      end else begin
        stg_nxt[StgIn].k[i] = '0;
      end
    end

    // First level: all products that need only the inputs.
    stg_nxt[StgM1].p[0] = mul_full(stg_r[StgIn].k[3], stg_r[StgIn].wq);
    stg_nxt[StgM1].p[1] = mul_full(stg_r[StgIn].k[6], stg_r[StgIn].e);
    stg_nxt[StgM1].p[2] = mul_full(stg_r[StgIn].k[4], stg_r[StgIn].v);
    stg_nxt[StgM1].p[3] = mul_full(stg_r[StgIn].k[7], stg_r[StgIn].ih);
    stg_nxt[StgM1].p[4] = mul_full(stg_r[StgIn].k[8], stg_r[StgIn].a);
    stg_nxt[StgM1].p[5] = mul_full(stg_r[StgIn].k[9], stg_r[StgIn].b);
    stg_nxt[StgM1].p[6] = mul_full(stg_r[StgIn].b, stg_r[StgIn].b);

    stg_nxt[StgR1].t_c2   = add_sat(stg_r[StgM1].k[2], rnd_sat(stg_r[StgM1].p[0]));
    stg_nxt[StgR1].t_c5   = add_sat(stg_r[StgM1].k[5], rnd_sat(stg_r[StgM1].p[1]));
    stg_nxt[StgR1].f1     = add_sat(OneQ, rnd_sat(stg_r[StgM1].p[2]));
    stg_nxt[StgR1].f3     = add_sat(OneQ, rnd_sat(stg_r[StgM1].p[3]));
    stg_nxt[StgR1].f4     = add_sat(OneQ, rnd_sat(stg_r[StgM1].p[4]));
    stg_nxt[StgR1].f5pre  = add_sat(OneQ, rnd_sat(stg_r[StgM1].p[5]));
    stg_nxt[StgR1].bb     = rnd_sat(stg_r[StgM1].p[6]);
    stg_nxt[StgR1].one_k1 = add_sat(OneQ, stg_r[StgM1].k[1]);

    // Second level: the inner terms of the weight, conductance and cubic factors.
    stg_nxt[StgM2].p[0] = mul_full(stg_r[StgR1].wq, stg_r[StgR1].t_c2);
    stg_nxt[StgM2].p[1] = mul_full(stg_r[StgR1].e, stg_r[StgR1].t_c5);
    stg_nxt[StgM2].p[2] = mul_full(stg_r[StgR1].k[10], stg_r[StgR1].bb);

    stg_nxt[StgR2].t_f0  = add_sat(stg_r[StgM2].one_k1, rnd_sat(stg_r[StgM2].p[0]));
    stg_nxt[StgR2].f2    = add_sat(OneQ, rnd_sat(stg_r[StgM2].p[1]));
    stg_nxt[StgR2].t_c19 = add_sat(stg_r[StgM2].k[9], rnd_sat(stg_r[StgM2].p[2]));

    // Third level: the weight factor and the cubic post-trace factor.
    stg_nxt[StgM3].p[0] = mul_full(stg_r[StgR2].k[0], stg_r[StgR2].t_f0);
    stg_nxt[StgM3].p[1] = mul_full(stg_r[StgR2].b, stg_r[StgR2].t_c19);

    stg_nxt[StgR3].dw = rnd_sat(stg_r[StgM3].p[0]);
    if (stg_r[StgM3].op) begin
      stg_nxt[StgR3].last = add_sat(OneQ, rnd_sat(stg_r[StgM3].p[1]));
    end else begin
      stg_nxt[StgR3].last = stg_r[StgM3].f5pre;
    end

    // Product chain, one factor per level in the order of the rule.
    stg_nxt[StgM4].p[0] = mul_full(stg_r[StgR3].dw, stg_r[StgR3].f1);
    stg_nxt[StgR4].dw   = rnd_sat(stg_r[StgM4].p[0]);
    stg_nxt[StgM5].p[0] = mul_full(stg_r[StgR4].dw, stg_r[StgR4].f2);
    stg_nxt[StgR5].dw   = rnd_sat(stg_r[StgM5].p[0]);
    stg_nxt[StgM6].p[0] = mul_full(stg_r[StgR5].dw, stg_r[StgR5].f3);
    stg_nxt[StgR6].dw   = rnd_sat(stg_r[StgM6].p[0]);
    stg_nxt[StgM7].p[0] = mul_full(stg_r[StgR6].dw, stg_r[StgR6].f4);
    stg_nxt[StgR7].dw   = rnd_sat(stg_r[StgM7].p[0]);
    stg_nxt[StgM8].p[0] = mul_full(stg_r[StgR7].dw, stg_r[StgR7].last);
    stg_nxt[StgR8].dw   = rnd_sat(stg_r[StgM8].p[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      for (int k = 0; k < PipeDepth; k++) begin
        if (en[k]) begin
          pv_r[k] <= pv_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PipeDepth; k++) begin
      if (en[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // Final stage, learning on: add the update to the weight and clip to zero and max_weight.
  always_comb begin
    sum   = $signed({{(AccWidth + 1 - WeightWidth){1'b0}}, stg_r[StgR8].w})
          + $signed({stg_r[StgR8].dw[AccWidth-1], stg_r[StgR8].dw});
    limit = $signed({{(AccWidth + 1 - WeightWidth){1'b0}}, cfg_st.max_weight});
    out_nxt.new_weight = stg_r[StgR8].w;
    out_nxt.clipped    = 1'b0;
    if (cfg_st.learn_enable) begin
      if (sum > limit) begin
        out_nxt.new_weight = cfg_st.max_weight;
        out_nxt.clipped    = 1'b1;
      end else if (sum < 0) begin
        out_nxt.new_weight = '0;
        out_nxt.clipped    = 1'b1;
      end else begin
        out_nxt.new_weight = sum[WeightWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= pv_r[StgR8];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // The input is held back only when every stage is full and the output is stalled.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&pv_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  // An accepted item lands in the input stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> pv_r[StgIn])
    else $error("accepted item lost at the input stage");

  // The pre rule keeps its linear post-trace factor as the last factor.
  a_pre_last_factor: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r[StgR3] && !stg_r[StgR3].op) |-> (stg_r[StgR3].last == stg_r[StgR3].f5pre))
    else $error("wrong last factor selected for the pre rule");

  // With learning off an item leaves with its weight unchanged and no clip flag.
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r[StgR8] && en_out && !cfg_st.learn_enable)
      |=> (out_r.new_weight == $past(stg_r[StgR8].w) && !out_r.clipped))
    else $error("weight changed while learning is disabled");
`endif

endmodule

FILE: tb/sv/polynomial_plasticity_weight_update_unit_tb.sv
// Self-checking testbench for the polynomial plasticity weight update unit.
module polynomial_plasticity_weight_update_unit_tb;
  import ppwu_pkg::*;

  localparam int HalfPeriod   = 5;
  localparam int ResetCycles  = 8;
  localparam int FracBits     = DefFracBits;
  localparam int CoefBits     = DefCoeffWidth;
  localparam int QuietLimit   = 5000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 24;
  localparam int NumPhases    = 12;
  localparam int PhaseItems   = 100;
  localparam int MaxReports   = 10;
  localparam longint AccHi    = 64'sd2147483647;
  localparam longint AccLo    = -64'sd2147483648;

  typedef struct packed {
    bit                      is_write;
    cfg_reg_t                target;
    logic [CfgDataWidth-1:0] wdata;
    in_item_t                item;
    bit                      typed;
    out_item_t               want;
  } vector_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_data;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;

  logic [CfgDataWidth-1:0] coef_words [6];
  logic [WeightWidth-1:0]  weight_cap;
  logic                    learn_on;

  out_item_t pending_weights [$];
  out_item_t next_expect;
  out_item_t oldest;
  vector_t   vectors [$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        stall_mode = 0;
  int        stall_left = 0;
  bit        hold_off_req = 1'b0;

  polynomial_plasticity_weight_update_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HalfPeriod clk = ~clk;

  function automatic longint clamp_acc(input longint x);
    if (x > AccHi) return AccHi;
    if (x < AccLo) return AccLo;
    return x;
  endfunction

  function automatic longint sum_q(input longint a, input longint b);
    return clamp_acc(a + b);
  endfunction

  function automatic longint mul_q(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FracBits - 1));
    return clamp_acc(p >>> FracBits);
  endfunction

  function automatic longint coef(input int n);
    logic signed [CoefBits-1:0] c;
    c = coef_words[n / CoeffsPerWord][(n % CoeffsPerWord) * CoeffStride +: CoefBits];
    return longint'(c);
  endfunction

  function automatic out_item_t predict_weight(input in_item_t it);
    out_item_t res;
    longint one, w, a, b, v, e, ih, dw, last, total;
    int base;
    one = 64'sd1 <<< FracBits;
    res.new_weight = it.weight;
    res.clipped = 1'b0;
    if (!learn_on) return res;
    w = longint'(it.weight);
    a = longint'(it.pre_trace) * RescaleTrace;
    b = longint'(it.post_trace) * RescaleTrace;
    v = longint'($signed(it.voltage)) * RescaleV;
    e = longint'(it.exc_conductance) * RescaleC;
    ih = longint'(it.inh_conductance) * RescaleC;
    base = it.opcode ? PostBase : 0;
    dw = mul_q(coef(base), sum_q(sum_q(one, coef(base + 1)),
               mul_q(w, sum_q(coef(base + 2), mul_q(coef(base + 3), w)))));
    dw = mul_q(dw, sum_q(one, mul_q(coef(base + 4), v)));
    dw = mul_q(dw, sum_q(one, mul_q(e, sum_q(coef(base + 5), mul_q(coef(base + 6), e)))));
    dw = mul_q(dw, sum_q(one, mul_q(coef(base + 7), ih)));
    dw = mul_q(dw, sum_q(one, mul_q(coef(base + 8), a)));
    if (it.opcode) begin
      last = sum_q(one, mul_q(b, sum_q(coef(base + 9), mul_q(coef(base + 10), mul_q(b, b)))));
    end else begin
      last = sum_q(one, mul_q(coef(base + 9), b));
    end
    dw = mul_q(dw, last);
    total = w + dw;
    if (total > longint'(weight_cap)) begin
      res.new_weight = weight_cap;
      res.clipped = 1'b1;
    end else if (total < 0) begin
      res.new_weight = '0;
      res.clipped = 1'b1;
    end else begin
      res.new_weight = total[WeightWidth-1:0];
    end
    return res;
  endfunction

  function automatic void apply_write(input cfg_reg_t sel, input logic [CfgDataWidth-1:0] d);
    case (sel)
      REG_COEFF_WORD_0, REG_COEFF_WORD_1, REG_COEFF_WORD_2, REG_COEFF_WORD_3,
      REG_COEFF_WORD_4: coef_words[int'(sel)] = d;
      REG_COEFF_WORD_5: coef_words[int'(sel)] = {48'h0, d[15:0]};
      REG_MAX_WEIGHT: weight_cap = d[WeightWidth-1:0];
      REG_LEARNING_ENABLE: learn_on = d[0];
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk_item(input int op, input int w, input int pre, input int post,
                                       input int volt, input int exc, input int inh);
    in_item_t it;
    it.opcode = 1'(op);
    it.weight = WeightWidth'(w);
    it.pre_trace = TraceWidth'(pre);
    it.post_trace = TraceWidth'(post);
    it.voltage = VoltWidth'(volt);
    it.exc_conductance = TraceWidth'(exc);
    it.inh_conductance = TraceWidth'(inh);
    return it;
  endfunction

  function automatic out_item_t mk_out(input int w, input int clip);
    out_item_t r;
    r.new_weight = WeightWidth'(w);
    r.clipped = 1'(clip);
    return r;
  endfunction

  function automatic void add_item(input in_item_t it, input int typed, input out_item_t want);
    vector_t row;
    row = '0;
    row.item = it;
    row.typed = (typed != 0);
    row.want = want;
    vectors.push_back(row);
  endfunction

  function automatic void add_write(input cfg_reg_t sel, input logic [CfgDataWidth-1:0] d);
    vector_t row;
    row = '0;
    row.is_write = 1'b1;
    row.target = sel;
    row.wdata = d;
    vectors.push_back(row);
  endfunction

  function automatic void build_vectors();
    add_item(mk_item(0, 0, 0, 0, 16'h0000, 0, 0), 1, mk_out(0, 0));
    add_item(mk_item(1, 4096, 32767, 32767, 16'h7FFF, 32767, 32767), 1, mk_out(4096, 0));
    add_item(mk_item(0, 4097, 100, 200, 16'h0010, 300, 400), 1, mk_out(4096, 1));
    add_item(mk_item(1, 32767, 0, 0, 16'h8000, 0, 0), 1, mk_out(4096, 1));
    add_write(REG_LEARNING_ENABLE, 64'h0);
    add_item(mk_item(0, 32767, 32767, 32767, 16'h8000, 32767, 32767), 1, mk_out(32767, 0));
    add_item(mk_item(1, 12345, 5, 6, 16'h1234, 7, 8), 1, mk_out(12345, 0));
    add_write(REG_LEARNING_ENABLE, 64'h1);
    add_write(REG_MAX_WEIGHT, 64'h7FFF);
    add_write(REG_COEFF_WORD_0, 64'h0000_0000_0000_1000);
    add_item(mk_item(0, 1000, 10, 20, 16'h0100, 30, 40), 0, '0);
    add_item(mk_item(1, 1000, 10, 20, 16'h0100, 30, 40), 0, '0);
    add_write(REG_COEFF_WORD_0, 64'h7FFF_7FFF_7FFF_7FFF);
    add_write(REG_COEFF_WORD_1, 64'h7FFF_7FFF_7FFF_7FFF);
    add_write(REG_COEFF_WORD_2, 64'h7FFF_7FFF_7FFF_7FFF);
    add_write(REG_COEFF_WORD_3, 64'h7FFF_7FFF_7FFF_7FFF);
    add_write(REG_COEFF_WORD_4, 64'h7FFF_7FFF_7FFF_7FFF);
    add_write(REG_COEFF_WORD_5, 64'h0000_0000_0000_7FFF);
    add_item(mk_item(0, 32767, 32767, 32767, 16'h7FFF, 32767, 32767), 0, '0);
    add_item(mk_item(1, 32767, 32767, 32767, 16'h7FFF, 32767, 32767), 0, '0);
    add_item(mk_item(1, 16384, 32767, 32767, 16'h8000, 32767, 32767), 0, '0);
    add_item(mk_item(0, 0, 0, 0, 16'h0000, 0, 0), 0, '0);
    add_write(REG_COEFF_WORD_0, 64'h8000_8000_8000_8000);
    add_write(REG_COEFF_WORD_1, 64'h8000_8000_8000_8000);
    add_write(REG_COEFF_WORD_2, 64'h8000_8000_8000_8000);
    add_write(REG_COEFF_WORD_3, 64'h8000_8000_8000_8000);
    add_write(REG_COEFF_WORD_4, 64'h8000_8000_8000_8000);
    add_write(REG_COEFF_WORD_5, 64'hFFFF_FFFF_FFFF_8000);
    add_item(mk_item(0, 32767, 32767, 32767, 16'h7FFF, 32767, 32767), 0, '0);
    add_item(mk_item(1, 32767, 32767, 32767, 16'h7FFF, 32767, 32767), 0, '0);
    add_item(mk_item(1, 32767, 0, 0, 16'h0000, 0, 0), 0, '0);
    add_write(REG_MAX_WEIGHT, 64'h0);
    add_item(mk_item(0, 0, 0, 0, 16'h0000, 0, 0), 0, '0);
    add_item(mk_item(1, 32767, 1, 1, 16'hFFFF, 1, 1), 0, '0);
    add_write(REG_COEFF_WORD_0, 64'hFF00_0080_0400_0800);
    add_write(REG_COEFF_WORD_1, 64'h0004_FFF8_0010_FFFC);
    add_write(REG_COEFF_WORD_2, 64'h0010_FFF0_0100_0020);
    add_write(REG_COEFF_WORD_3, 64'h0002_FFFE_0040_0008);
    add_write(REG_COEFF_WORD_4, 64'hFFF0_0020_0004_FFFC);
    add_write(REG_COEFF_WORD_5, 64'h0000_0000_0000_0001);
    add_write(REG_MAX_WEIGHT, 64'd20000);
    add_item(mk_item(0, 8000, 2000, 3000, 16'hF000, 1500, 2500), 0, '0);
    add_item(mk_item(1, 8000, 2000, 3000, 16'h0F00, 1500, 2500), 0, '0);
    add_item(mk_item(0, 19990, 50, 60, 16'h0040, 70, 80), 0, '0);
  endfunction

  function automatic logic [15:0] pick_coeff(input int profile);
    int k;
    int val;
    case (profile)
      1: begin
        k = 1 << $urandom_range(0, 9);
        val = int'($urandom_range(0, 2 * k)) - k;
        return val[15:0];
      end
      2: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return 16'h7FFF;
          2: return 16'h8000;
          3: return 16'hFFFF;
          4: return 16'h1000;
          default: return 16'hF000;
        endcase
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CfgDataWidth-1:0] reg_value(input cfg_reg_t sel, input int profile,
                                                        input int ph);
    logic [CfgDataWidth-1:0] d;
    d = {$urandom, $urandom};
    case (sel)
      REG_COEFF_WORD_5: d[15:0] = pick_coeff(profile);
      REG_MAX_WEIGHT: begin
        if (ph % 6 == 0) d[WeightWidth-1:0] = '1;
        else if (ph % 6 == 1) d[WeightWidth-1:0] = '0;
      end
      REG_LEARNING_ENABLE: d[0] = (ph != 7);
      default: begin
        if (profile != 0) begin
          for (int j = 0; j < CoeffsPerWord; j++) d[j * CoeffStride +: 16] = pick_coeff(profile);
        end
      end
    endcase
    return d;
  endfunction

  function automatic logic [14:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 15'd0;
      1: return 15'h7FFF;
      2, 3: return 15'($urandom_range(0, 1023));
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int x;
    it.opcode = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      x = int'(weight_cap) + int'($urandom_range(0, 64)) - 32;
      if (x < 0) x = 0;
      if (x > 32767) x = 32767;
      it.weight = x[14:0];
    end else begin
      it.weight = pick_field();
    end
    it.pre_trace = pick_field();
    it.post_trace = pick_field();
    case ($urandom_range(0, 7))
      0: it.voltage = 16'h8000;
      1: it.voltage = 16'h7FFF;
      2, 3: begin
        x = int'($urandom_range(0, 2047)) - 1024;
        it.voltage = x[15:0];
      end
      default: it.voltage = 16'($urandom_range(0, 65535));
    endcase
    it.exc_conductance = pick_field();
    it.inh_conductance = pick_field();
    return it;
  endfunction

  task automatic push_item(input in_item_t it, input out_item_t exp_w);
    in_valid = 1'b1;
    in_data = it;
    next_expect = exp_w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_for(input int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_weights.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CfgDataWidth-1:0] d);
    cfg_valid = 1'b1;
    cfg_index = sel;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_write(sel, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && !in_stall) pending_weights.push_back(next_expect);
      if (out_valid && !out_stall) begin
        if (pending_weights.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("Unexpected result: new_weight=%0d clipped=%0d",
                     out_data.new_weight, out_data.clipped);
        end else begin
          oldest = pending_weights.pop_front();
          if (out_data.new_weight !== oldest.new_weight || out_data.clipped !== oldest.clipped)
          begin
            mismatch_count++;
            if (mismatch_count <= MaxReports)
              $display("Mismatch: new_weight exp %0d got %0d, clipped exp %0d got %0d",
                       oldest.new_weight, out_data.new_weight, oldest.clipped,
                       out_data.clipped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = 1'($urandom_range(0, 1));
        2: out_stall = ($urandom_range(0, 9) < 8);
        default: out_stall = (stall_left % 5 < 2);
      endcase
    end
  end

  initial begin
    vector_t  row;
    in_item_t it;
    int       sent;
    int       n_burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    next_expect = '0;
    foreach (coef_words[i]) coef_words[i] = '0;
    weight_cap = MaxWeightReset;
    learn_on = 1'b1;
    build_vectors();
    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (vectors[i]) begin
      row = vectors[i];
      if (row.is_write) begin
        drain();
        write_reg(row.target, row.wdata);
      end else begin
        push_item(row.item, row.typed ? row.want : predict_weight(row.item));
        if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 3));
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      for (int r = 0; r <= int'(REG_LEARNING_ENABLE); r++)
        write_reg(cfg_reg_t'(r), reg_value(cfg_reg_t'(r), ph % 3, ph));
      // The long receiver hold-off runs while items keep coming back to back.
      if (ph == 2) hold_off_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        n_burst = (ph == 2) ? PhaseItems : $urandom_range(1, 40);
        for (int k = 0; k < n_burst && sent < PhaseItems; k++) begin
          it = rand_item();
          push_item(it, predict_weight(it));
          sent++;
          if (ph == 4 && sent == PhaseItems / 2) drain();
        end
        if (ph != 2 && $urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_weights.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
